// ----- design/i2p_pkg.sv -----
`default_nettype none

package i2p_pkg;

  localparam int StackDepth = 32;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  typedef enum logic [2:0] {
    CODE_ADD    = 3'd0,
    CODE_SUB    = 3'd1,
    CODE_MUL    = 3'd2,
    CODE_DIV    = 3'd3,
    CODE_RPAREN = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP,
    SH_POP2
  } shift_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_UNMATCHED = 2'd2,
    ERR_UNKNOWN   = 2'd3
  } err_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic op_code_t char_to_code(input logic [7:0] c);
    op_code_t code;
    code = CODE_ADD;
    if (c == CH_MINUS) code = CODE_SUB;
    if (c == CH_STAR)  code = CODE_MUL;
    if (c == CH_SLASH) code = CODE_DIV;
    return code;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      CODE_ADD:    c = CH_PLUS;
      CODE_SUB:    c = CH_MINUS;
      CODE_MUL:    c = CH_STAR;
      CODE_DIV:    c = CH_SLASH;
      CODE_RPAREN: c = CH_RPAREN;
      default:     c = CH_PLUS;
    endcase
    return c;
  endfunction

  function automatic logic is_high_prec(input op_code_t code);
    return code >= CODE_MUL;
  endfunction

endpackage

`default_nettype wire

// ----- design/i2p_cell.sv -----
`default_nettype none

module i2p_cell (
  input  logic               clk,
  input  i2p_pkg::shift_t    shift,
  input  i2p_pkg::op_code_t  above,
  input  i2p_pkg::op_code_t  below1,
  input  i2p_pkg::op_code_t  below2,
  output i2p_pkg::op_code_t  code
);
  import i2p_pkg::*;

  always_ff @(posedge clk) begin
    unique case (shift)
      SH_HOLD: code <= code;
      SH_PUSH: code <= above;
      SH_POP:  code <= below1;
      SH_POP2: code <= below2;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/infix_to_prefix_converter.sv -----
// Infix to prefix converter with an operator stack built as a row of cells.
// Input channel s_*: one character of the reversed infix expression per item,
// s_tlast marks the final character of an expression.
// Output channel m_*: one item per emitted result, m_tdata the character,
// m_tuser the has-char flag and an error code, m_tlast on the final result of
// the final character.
// Each input item is accepted in the idle state and handled in the main state,
// one step per result it causes (pass-through, each pop, each error), plus a
// step for a push or a discarded ')' that emits nothing. A final item then
// passes through the flush state, which pops each remaining entry as a result
// and closes even when the stack is already empty. Popping for a '(' removes
// the matching ')' in the same cycle as the last pop. The stack shifts its
// whole row of cells by one or two positions, so a single pop or push sets the
// pace. The item is captured in cur_char, and its results pass through the
// output register. s_tready is high only between items.
// Reset clears the stack count, the control state and the output valid flag.
// While the receiver stalls, the pending result holds in the output register
// and work on the current item waits.

`default_nettype none

module infix_to_prefix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::StackDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_char
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic [2:0] m_tuser,   // has_char, error_code[1:0]
  output logic       m_tlast    // out_last
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           emitted, emitted_next;
  logic [7:0]     cur_char;
  logic           cur_last;

  shift_t         shift;
  op_code_t       push_code;
  op_code_t       cell_q [STACK_DEPTH];
  op_code_t       ext_q  [STACK_DEPTH + 2];

  logic           slot_free;
  logic           emit;
  logic [7:0]     e_char;
  logic           e_has;
  err_t           e_err;
  logic           e_last;
  logic           done;
  logic           full;
  op_code_t       top;
  op_code_t       second;

  // stack row, cell 0 is the top
  assign ext_q[STACK_DEPTH]     = CODE_ADD;
  assign ext_q[STACK_DEPTH + 1] = CODE_ADD;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    op_code_t above;
    assign ext_q[i] = cell_q[i];
    if (i == 0) begin : g_top
      assign above = push_code;
    end else begin : g_rest
      assign above = cell_q[i-1];
    end
    i2p_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .above  (above),
      .below1 (ext_q[i+1]),
      .below2 (ext_q[i+2]),
      .code   (cell_q[i])
    );
  end

  assign top       = cell_q[0];
  assign second    = cell_q[1];
  assign full      = (count == CW'(STACK_DEPTH));
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    emitted_next = emitted;
    shift        = SH_HOLD;
    push_code    = CODE_ADD;
    emit         = 1'b0;
    e_char       = 8'd0;
    e_has        = 1'b0;
    e_err        = ERR_NONE;
    e_last       = 1'b0;
    done         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next   = ST_MAIN;
          emitted_next = 1'b0;
        end
      end
      ST_MAIN: begin
        if (slot_free) begin
          priority if (is_alnum(cur_char)) begin
            emit   = 1'b1;
            e_char = cur_char;
            e_has  = 1'b1;
            done   = 1'b1;
          end else if (cur_char == CH_RPAREN) begin
            if (full) begin
              emit  = 1'b1;
              e_err = ERR_FULL;
            end else begin
              shift      = SH_PUSH;
              push_code  = CODE_RPAREN;
              count_next = count + CW'(1);
            end
            done = 1'b1;
          end else if (cur_char == CH_LPAREN) begin
            if (count != '0 && top != CODE_RPAREN) begin
              emit   = 1'b1;
              e_char = code_char(top);
              e_has  = 1'b1;
              if (count >= CW'(2) && second == CODE_RPAREN) begin
                // pop and drop the matching ')' together
                shift      = SH_POP2;
                count_next = count - CW'(2);
                done       = 1'b1;
              end else begin
                shift      = SH_POP;
                count_next = count - CW'(1);
              end
            end else if (count != '0) begin
              shift      = SH_POP;
              count_next = count - CW'(1);
              done       = 1'b1;
            end else begin
              emit  = 1'b1;
              e_err = ERR_UNMATCHED;
              done  = 1'b1;
            end
          end else if (is_operator(cur_char)) begin
            if (count != '0 && top != CODE_RPAREN && is_high_prec(top) &&
                !is_high_prec(char_to_code(cur_char))) begin
              emit       = 1'b1;
              e_char     = code_char(top);
              e_has      = 1'b1;
              shift      = SH_POP;
              count_next = count - CW'(1);
            end else if (full) begin
              emit  = 1'b1;
              e_err = ERR_FULL;
              done  = 1'b1;
            end else begin
              shift      = SH_PUSH;
              push_code  = char_to_code(cur_char);
              count_next = count + CW'(1);
              done       = 1'b1;
            end
          end else begin
            emit  = 1'b1;
            e_err = ERR_UNKNOWN;
            done  = 1'b1;
          end
          if (done) begin
            state_next = cur_last ? ST_FLUSH : ST_IDLE;
            e_last     = cur_last && (count_next == '0);
          end
          emitted_next = emitted | emit;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          if (count != '0) begin
            emit       = 1'b1;
            e_char     = code_char(top);
            e_has      = 1'b1;
            e_last     = (count == CW'(1));
            shift      = SH_POP;
            count_next = count - CW'(1);
            if (count == CW'(1)) begin
              state_next = ST_IDLE;
            end
          end else begin
            // final item with nothing emitted gets one empty result
            emit       = !emitted;
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end
          emitted_next = emitted | emit;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      emitted  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      emitted <= emitted_next;
      if (slot_free && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cur_char <= s_tdata;
      cur_last <= s_tlast;
    end
    if (slot_free && emit) begin
      m_tdata <= e_char;
      m_tuser <= {e_err, e_has};
      m_tlast <= e_last;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_infix_to_prefix_converter.sv -----
`timescale 1ns / 100ps

module tb_infix_to_prefix_converter;
  import i2p_pkg::*;

  typedef struct packed {
    logic       drain;
    logic       last;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    err_t       err;
  } prefix_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // in_char
  logic       s_tlast = 1'b0;    // in_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // out_char
  logic [2:0] m_tuser;           // has_char, error_code[1:0]
  logic       m_tlast;           // out_last

  char_item_t     pending_chars[$];
  prefix_result_t expected_prefix[$];
  prefix_result_t step_results[$];
  logic [7:0]     expr_chars[$];

  op_code_t op_stack[StackDepth];
  int       op_depth = 0;

  int queued = 0;
  int chars_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int expr_count = 0;
  int err_seen[4] = '{0, 0, 0, 0};
  int tx_burst_left = 0;
  int tx_gap_left = 0;
  int rx_cycle = 0;
  int rx_hold_left = 0;
  logic rx_hold_done = 1'b0;
  logic [7:0] rx_mask = 8'hFF;

  infix_to_prefix_converter uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic is_operand_char(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    case (code)
      CODE_ADD: return CH_PLUS;
      CODE_SUB: return CH_MINUS;
      CODE_MUL: return CH_STAR;
      CODE_DIV: return CH_SLASH;
      default:  return CH_RPAREN;
    endcase
  endfunction

  function automatic logic binds_tight(input op_code_t code);
    return code == CODE_MUL || code == CODE_DIV;
  endfunction

  function automatic prefix_result_t result_of(input logic [7:0] ch, input logic has,
                                               input err_t err);
    return {ch, has, 1'b0, err};
  endfunction

  task automatic pop_op();
    op_depth--;
    step_results.push_back(result_of(op_char(op_stack[op_depth]), 1'b1, ERR_NONE));
  endtask

  task automatic push_op(input op_code_t code);
    if (op_depth >= StackDepth) begin
      step_results.push_back(result_of(8'h00, 1'b0, ERR_FULL));
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endtask

  task automatic convert_char(input logic [7:0] ch, input logic last);
    op_code_t       code;
    logic           is_op;
    prefix_result_t tail;
    step_results.delete();
    is_op = 1'b1;
    code = CODE_ADD;
    case (ch)
      CH_PLUS:  code = CODE_ADD;
      CH_MINUS: code = CODE_SUB;
      CH_STAR:  code = CODE_MUL;
      CH_SLASH: code = CODE_DIV;
      default:  is_op = 1'b0;
    endcase
    if (is_operand_char(ch)) begin
      step_results.push_back(result_of(ch, 1'b1, ERR_NONE));
    end else if (ch == CH_RPAREN) begin
      push_op(CODE_RPAREN);
    end else if (ch == CH_LPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CODE_RPAREN) pop_op();
      if (op_depth > 0) op_depth--;
      else step_results.push_back(result_of(8'h00, 1'b0, ERR_UNMATCHED));
    end else if (is_op) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CODE_RPAREN &&
             binds_tight(op_stack[op_depth-1]) && !binds_tight(code)) pop_op();
      push_op(code);
    end else begin
      step_results.push_back(result_of(8'h00, 1'b0, ERR_UNKNOWN));
    end
    if (last) begin
      while (op_depth > 0) pop_op();
      if (step_results.size() == 0) step_results.push_back(result_of(8'h00, 1'b0, ERR_NONE));
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
    foreach (step_results[i]) expected_prefix.push_back(step_results[i]);
  endtask

  task automatic add_char(input logic [7:0] ch, input logic last, input logic drain = 1'b0);
    pending_chars.push_back({drain, last, ch});
    queued++;
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return CH_0 + 8'($urandom_range(0, 9));
      1:       return CH_LA + 8'($urandom_range(0, 25));
      default: return CH_UA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_token();
    case ($urandom_range(0, 5))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2, 3:    return rand_operator();
      default: return rand_operand();
    endcase
  endfunction

  task automatic gen_expr(input int depth);
    int pick;
    pick = (depth == 0) ? 0 : $urandom_range(0, 5);
    if (pick < 2) begin
      expr_chars.push_back(rand_operand());
    end else if (pick == 2) begin
      expr_chars.push_back(CH_LPAREN);
      gen_expr(depth - 1);
      expr_chars.push_back(CH_RPAREN);
    end else begin
      gen_expr(depth - 1);
      expr_chars.push_back(rand_operator());
      gen_expr(depth - 1);
    end
  endtask

  // the host feeds the infix string right to left
  task automatic queue_expr(input logic drain);
    for (int i = expr_chars.size() - 1; i >= 0; i--)
      add_char(expr_chars[i], i == 0, drain && i == expr_chars.size() - 1);
    expr_chars.delete();
    expr_count++;
  endtask

  always @(posedge clk) begin : tx_side
    char_item_t item;
    logic       fire;
    logic       present;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tlast <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        convert_char(s_tdata, s_tlast);
        chars_sent++;
      end
      if (!s_tvalid || fire) begin
        present = 1'b0;
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && (fire || expected_prefix.size() != 0))) begin
          item = pending_chars.pop_front();
          present = 1'b1;
          s_tdata <= item.ch;
          s_tlast <= item.last;
          if (tx_burst_left > 1) begin
            tx_burst_left--;
          end else begin
            tx_burst_left = $urandom_range(1, 16);
            tx_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_tvalid <= present;
      end
    end
  end

  always @(posedge clk) begin : rx_side
    prefix_result_t want;
    logic           next_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_prefix.size() == 0) begin
          $display("%0t: unexpected result: data %h user %b last %b", $time, m_tdata,
                   m_tuser, m_tlast);
          mismatch_count++;
        end else begin
          want = expected_prefix.pop_front();
          results_checked++;
          err_seen[want.err]++;
          if (m_tdata !== want.ch || m_tuser[0] !== want.has ||
              m_tuser[2:1] !== want.err || m_tlast !== want.last) begin
            $display("%0t: mismatch: expected %h %b %0d %b, actual %h %b %0d %b",
                     $time, want.ch, want.has, want.err, want.last, m_tdata, m_tuser[0],
                     m_tuser[2:1], m_tlast);
            mismatch_count++;
          end
        end
      end
      if (rx_cycle % 64 == 0)
        rx_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      next_ready = rx_mask[rx_cycle % 8];
      rx_cycle++;
      // one long hold so the block backs up into its input
      if (!rx_hold_done && chars_sent >= 120) begin
        rx_hold_done = 1'b1;
        rx_hold_left = 400;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        next_ready = 1'b0;
      end
      m_tready <= next_ready;
    end
  end

  initial begin : stimulus
    int pick;
    int nest;
    int idx;
    // matched pair with nothing else: empty final result
    add_char(CH_RPAREN, 1'b0);
    add_char(CH_LPAREN, 1'b1);
    // unmatched open paren on an empty stack
    add_char(CH_LPAREN, 1'b1);
    // unknown characters at both ends of the byte range
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    // A-9/z+0*Z reversed
    add_char(CH_UZ, 1'b0);
    add_char(CH_STAR, 1'b0);
    add_char(CH_0, 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char(CH_LZ, 1'b0);
    add_char(CH_SLASH, 1'b0);
    add_char(CH_9, 1'b0);
    add_char(CH_MINUS, 1'b0);
    add_char(CH_UA, 1'b1);
    // a/(Z-0) reversed
    add_char(CH_RPAREN, 1'b0);
    add_char(CH_0, 1'b0);
    add_char(CH_MINUS, 1'b0);
    add_char(CH_UZ, 1'b0);
    add_char(CH_LPAREN, 1'b0);
    add_char(CH_SLASH, 1'b0);
    add_char(CH_LA, 1'b1);
    // lone operator flushed at the end
    add_char(CH_MINUS, 1'b1);
    // open paren with operators but no close paren on the stack
    add_char(CH_LA, 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char(CH_LPAREN, 1'b1);

    for (int e = 0; queued < 365; e++) begin
      pick = $urandom_range(0, 99);
      if (e == 12 || pick < 2) begin
        // nesting near or past the stack depth
        nest = (e == 12) ? StackDepth + 1 : $urandom_range(StackDepth - 4, StackDepth + 2);
        repeat (nest) expr_chars.push_back(CH_LPAREN);
        gen_expr(1);
        repeat (nest) expr_chars.push_back(CH_RPAREN);
      end else if (pick < 72) begin
        gen_expr($urandom_range(0, 4));
      end else if (pick < 82) begin
        gen_expr($urandom_range(1, 3));
        idx = $urandom_range(0, expr_chars.size() - 1);
        case ($urandom_range(0, 2))
          0:       expr_chars.delete(idx);
          1:       expr_chars[idx] = rand_token();
          default: expr_chars.insert(idx, 8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 91) begin
        repeat ($urandom_range(1, 12)) expr_chars.push_back(rand_token());
      end else begin
        repeat ($urandom_range(1, 4))
          add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      if (expr_chars.size() != 0) queue_expr(e % 40 == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_prefix.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d characters in %0d sequences, %0d results checked", chars_sent, expr_count,
             results_checked);
    $display("results by error code: none %0d, stack full %0d, unmatched %0d, unknown %0d",
             err_seen[ERR_NONE], err_seen[ERR_FULL], err_seen[ERR_UNMATCHED],
             err_seen[ERR_UNKNOWN]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
